/* hdl/lbpm_pkg.sv */
// Shared types and constants for the linked block pool manager.
// Used by the core, its port checker and the testbench; depends on nothing else.
`timescale 1ns / 1ps

package lbpm_pkg;

  localparam int NUM_BLOCKS_DEF  = 1024;
  localparam int MAX_OBJECTS_DEF = 16;

  localparam int FUNC_W      = 3;
  localparam int KEY_W       = 64;
  localparam int BLK_FIELD_W = 10;
  localparam int STATUS_W    = 3;

  // stream payload widths, padded to whole bytes
  localparam int IN_TDATA_W  = 80;
  localparam int IN_TUSER_W  = 8;
  localparam int OUT_TDATA_W = 16;

  // request codes; code 7 has no meaning and is served by default arms
  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC     = 3'd0,
    FN_FREE      = 3'd1,
    FN_CREATE    = 3'd2,
    FN_APPEND    = 3'd3,
    FN_DROP      = 3'd4,
    FN_GET_FIRST = 3'd5,
    FN_GET_LAST  = 3'd6
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_NOT_FOUND  = 3'd1,
    ST_POOL_EMPTY = 3'd2,
    ST_DIR_FULL   = 3'd3,
    ST_BAD_BLOCK  = 3'd4
  } status_t;

endpackage

/* hdl/linked_block_pool_manager_core.sv */
// Top level of the linked block pool manager: request sequencer, key compare,
// link and directory RAMs (lbpm_ram), output register. Depends on lbpm_pkg and lbpm_ram.
`timescale 1ns / 1ps

// Serves one request at a time. After reset the link RAM is initialized by a
// sweep over all NUM_BLOCKS entries during which in_tready stays low. An unused
// code or an early error goes straight to the result. Name lookups scan the
// directory entry by entry (the single key comparator checks one entry per
// cycle), and drop then compacts the directory, moving each later entry down
// by one place. The result sits in an output register, so a new request is
// taken while a result is still waiting on out_tready.
module linked_block_pool_manager_core
  import lbpm_pkg::*;
#(
  parameter int NUM_BLOCKS  = lbpm_pkg::NUM_BLOCKS_DEF,
  parameter int MAX_OBJECTS = lbpm_pkg::MAX_OBJECTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [63:0] object_key, [73:64] block_number, [79:74] zero
  input  logic [lbpm_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [2:0] func, [7:3] zero
  input  logic [lbpm_pkg::IN_TUSER_W-1:0]    in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [9:0] result_block, [12:10] status, [15:13] zero
  output logic [lbpm_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int BW    = $clog2(NUM_BLOCKS);
  localparam int DW    = $clog2(MAX_OBJECTS);
  localparam int CW    = $clog2(MAX_OBJECTS + 1);
  localparam int DIR_W = KEY_W + 2 * BW;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_TAKE,
    S_FREE,
    S_SCAN,
    S_APP_LINK,
    S_APP_END,
    S_DROP_LINK,
    S_SHIFT,
    S_FIN
  } state_t;

  state_t              state_r, state_nxt;
  logic [BW-1:0]       clr_r, clr_nxt;
  logic [BW-1:0]       free_head_r, free_head_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic                pend_r, pend_nxt;
  logic [DW-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic [DW-1:0]       dst_r, dst_nxt;
  logic [DW-1:0]       e_r, e_nxt;
  logic [BW-1:0]       ent_first_r, ent_first_nxt;
  logic [BW-1:0]       ent_last_r, ent_last_nxt;
  func_t               func_r, func_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [BW-1:0]       blk_r, blk_nxt;
  logic [BW-1:0]       res_r, res_nxt;
  status_t             st_r, st_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [BLK_FIELD_W-1:0] out_res_r, out_res_nxt;
  status_t             out_st_r, out_st_nxt;

  // RAM ports
  logic                link_we;
  logic [BW-1:0]       link_wa;
  logic [BW-1:0]       link_wd;
  logic [BW-1:0]       link_rd;
  logic                dir_we;
  logic [DW-1:0]       dir_wa;
  logic [DIR_W-1:0]    dir_wd;
  logic [DW-1:0]       dir_ra;
  logic [DIR_W-1:0]    dir_rd;

  // input field unpacking
  func_t                  in_func;
  logic [KEY_W-1:0]       in_key;
  logic [BLK_FIELD_W-1:0] in_blk;
  logic [BW+BLK_FIELD_W-1:0] in_blk_ext;
  logic [BW-1:0]          in_blk_bw;
  logic                   in_blk_ok;

  logic [KEY_W-1:0]       rd_key;
  logic [BW-1:0]          rd_first;
  logic [BW-1:0]          rd_last;
  logic                   key_hit;
  logic [BW+BLK_FIELD_W-1:0] res_ext;

  assign in_func    = func_t'(in_tuser[FUNC_W-1:0]);
  assign in_key     = in_tdata[KEY_W-1:0];
  assign in_blk     = in_tdata[KEY_W+BLK_FIELD_W-1:KEY_W];
  assign in_blk_ext = {{BW{1'b0}}, in_blk};
  assign in_blk_bw  = in_blk_ext[BW-1:0];
  assign in_blk_ok  = (in_blk != '0) && (32'(in_blk) < 32'(NUM_BLOCKS));

  assign rd_key   = dir_rd[DIR_W-1:2*BW];
  assign rd_first = dir_rd[2*BW-1:BW];
  assign rd_last  = dir_rd[BW-1:0];

  // the shared comparator: one directory key per cycle
  assign key_hit = pend_r && (rd_key == key_r);

  assign res_ext = {{BLK_FIELD_W{1'b0}}, res_r};

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-BLK_FIELD_W-STATUS_W){1'b0}}, out_st_r, out_res_r};

  lbpm_ram #(.DEPTH(NUM_BLOCKS), .DATA_W(BW)) u_link_ram (
    .clk     (clk),
    .wr_en   (link_we),
    .wr_addr (link_wa),
    .wr_data (link_wd),
    .rd_addr (free_head_r),
    .rd_data (link_rd)
  );

  lbpm_ram #(.DEPTH(MAX_OBJECTS), .DATA_W(DIR_W)) u_dir_ram (
    .clk     (clk),
    .wr_en   (dir_we),
    .wr_addr (dir_wa),
    .wr_data (dir_wd),
    .rd_addr (dir_ra),
    .rd_data (dir_rd)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    free_head_nxt = free_head_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    cmp_idx_nxt   = cmp_idx_r;
    dst_nxt       = dst_r;
    e_nxt         = e_r;
    ent_first_nxt = ent_first_r;
    ent_last_nxt  = ent_last_r;
    func_nxt      = func_r;
    key_nxt       = key_r;
    blk_nxt       = blk_r;
    res_nxt       = res_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_res_nxt   = out_res_r;
    out_st_nxt    = out_st_r;

    link_we = 1'b0;
    link_wa = free_head_r;
    link_wd = '0;
    dir_we  = 1'b0;
    dir_wa  = e_r;
    dir_wd  = dir_rd;
    dir_ra  = idx_r[DW-1:0];

    unique case (state_r)
      S_CLEAR: begin
        link_we = 1'b1;
        link_wa = clr_r;
        if (clr_r == BW'(NUM_BLOCKS - 1)) begin
          link_wd   = '0;
          state_nxt = S_IDLE;
        end else begin
          link_wd = clr_r + 1'b1;
          clr_nxt = clr_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_tvalid) begin
          func_nxt = in_func;
          key_nxt  = in_key;
          blk_nxt  = in_blk_bw;
          idx_nxt  = '0;
          pend_nxt = 1'b0;
          res_nxt  = '0;
          st_nxt   = ST_OK;
          case (in_func)
            FN_ALLOC: begin
              if (free_head_r == '0) begin
                st_nxt    = ST_POOL_EMPTY;
                state_nxt = S_FIN;
              end else begin
                state_nxt = S_TAKE;
              end
            end
            FN_CREATE: begin
              if (count_r == CW'(MAX_OBJECTS)) begin
                st_nxt    = ST_DIR_FULL;
                state_nxt = S_FIN;
              end else if (free_head_r == '0) begin
                st_nxt    = ST_POOL_EMPTY;
                state_nxt = S_FIN;
              end else begin
                state_nxt = S_TAKE;
              end
            end
            FN_FREE: begin
              if (!in_blk_ok) begin
                st_nxt    = ST_BAD_BLOCK;
                state_nxt = S_FIN;
              end else begin
                state_nxt = S_FREE;
              end
            end
            FN_APPEND: begin
              if (!in_blk_ok) begin
                st_nxt    = ST_BAD_BLOCK;
                state_nxt = S_FIN;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            FN_DROP, FN_GET_FIRST, FN_GET_LAST: begin
              state_nxt = S_SCAN;
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end

      // link RAM data is next_link[free_head], read during the accept cycle
      S_TAKE: begin
        link_we       = 1'b1;
        link_wa       = free_head_r;
        link_wd       = '0;
        free_head_nxt = link_rd;
        res_nxt       = free_head_r;
        if (func_r == FN_CREATE) begin
          dir_we    = 1'b1;
          dir_wa    = count_r[DW-1:0];
          dir_wd    = {key_r, free_head_r, free_head_r};
          count_nxt = count_r + 1'b1;
        end
        state_nxt = S_FIN;
      end

      S_FREE: begin
        link_we       = 1'b1;
        link_wa       = blk_r;
        link_wd       = free_head_r;
        free_head_nxt = blk_r;
        state_nxt     = S_FIN;
      end

      // read of entry idx overlaps compare of the entry read last cycle
      S_SCAN: begin
        if (key_hit) begin
          e_nxt         = cmp_idx_r;
          ent_first_nxt = rd_first;
          ent_last_nxt  = rd_last;
          pend_nxt      = 1'b0;
          case (func_r)
            FN_APPEND: state_nxt = S_APP_LINK;
            FN_DROP:   state_nxt = S_DROP_LINK;
            FN_GET_FIRST: begin
              res_nxt   = rd_first;
              state_nxt = S_FIN;
            end
            default: begin
              res_nxt   = rd_last;
              state_nxt = S_FIN;
            end
          endcase
        end else if (idx_r < count_r) begin
          cmp_idx_nxt = idx_r[DW-1:0];
          pend_nxt    = 1'b1;
          idx_nxt     = idx_r + 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          st_nxt    = ST_NOT_FOUND;
          state_nxt = S_FIN;
        end
      end

      S_APP_LINK: begin
        link_we   = 1'b1;
        link_wa   = ent_last_r;
        link_wd   = blk_r;
        dir_we    = 1'b1;
        dir_wa    = e_r;
        dir_wd    = {key_r, ent_first_r, blk_r};
        state_nxt = S_APP_END;
      end

      // ordered after the link write so that appending the last block ends at 0
      S_APP_END: begin
        link_we   = 1'b1;
        link_wa   = blk_r;
        link_wd   = '0;
        state_nxt = S_FIN;
      end

      S_DROP_LINK: begin
        link_we       = 1'b1;
        link_wa       = ent_last_r;
        link_wd       = free_head_r;
        free_head_nxt = ent_first_r;
        idx_nxt       = CW'(e_r) + 1'b1;
        pend_nxt      = 1'b0;
        state_nxt     = S_SHIFT;
      end

      // compaction: read entry idx, write it one place down in the next cycle
      S_SHIFT: begin
        if (pend_r) begin
          dir_we = 1'b1;
          dir_wa = dst_r;
          dir_wd = dir_rd;
        end
        if (idx_r < count_r) begin
          dst_nxt  = DW'(idx_r - 1'b1);
          idx_nxt  = idx_r + 1'b1;
          pend_nxt = 1'b1;
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_ext[BLK_FIELD_W-1:0];
          out_st_nxt    = st_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      free_head_r <= BW'(1);
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      free_head_r <= free_head_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      cmp_idx_r   <= cmp_idx_nxt;
      dst_r       <= dst_nxt;
      e_r         <= e_nxt;
      ent_first_r <= ent_first_nxt;
      ent_last_r  <= ent_last_nxt;
      func_r      <= func_nxt;
      key_r       <= key_nxt;
      blk_r       <= blk_nxt;
      res_r       <= res_nxt;
      st_r        <= st_nxt;
      out_res_r   <= out_res_nxt;
      out_st_r    <= out_st_nxt;
    end
  end

endmodule

/* hdl/lbpm_ram.sv */
// Simple dual-port RAM: one write port, one read port with registered data.
// Used for the link memory and the object directory; no dependencies.
`timescale 1ns / 1ps

module lbpm_ram #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read returns the contents before a same-edge write
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* hdl/lbpm_checker.sv */
// Port-level checks for linked_block_pool_manager_core, attached by bind.
// Depends on lbpm_pkg for field widths and status codes.
`timescale 1ns / 1ps

module lbpm_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [lbpm_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import lbpm_pkg::*;

  logic [STATUS_W-1:0]    out_status;
  logic [BLK_FIELD_W-1:0] out_block;

  assign out_block  = out_tdata[BLK_FIELD_W-1:0];
  assign out_status = out_tdata[BLK_FIELD_W+STATUS_W-1:BLK_FIELD_W];

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  // one request in service at a time
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while another is in service");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_status == ST_OK) || (out_status == ST_NOT_FOUND) ||
                   (out_status == ST_POOL_EMPTY) || (out_status == ST_DIR_FULL) ||
                   (out_status == ST_BAD_BLOCK))
    else $error("undefined status code");

  // failed requests never report a block
  a_err_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_status != ST_OK) |-> (out_block == '0))
    else $error("block reported with an error status");

endmodule

bind linked_block_pool_manager_core lbpm_checker u_lbpm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* dv/tb.sv */
// Self-checking testbench for linked_block_pool_manager_core: a cycle-free model of the
// block pool and object directory predicts every reply. Depends on lbpm_pkg and the core.
`timescale 1ns / 1ps

module tb;
  import lbpm_pkg::*;

  localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;
  localparam logic [KEY_W-1:0]  KEY_ZERO  = '0;
  localparam logic [KEY_W-1:0]  KEY_ONES  = '1;
  localparam int RANDOM_ITEMS  = 320;
  localparam int PRINT_CAP     = 40;

  typedef struct packed {
    logic [BLK_FIELD_W-1:0] block;
    status_t                status;
  } pool_reply_t;

  // Mirrors the link memory and directory; queues predicted replies in order.
  class pool_scoreboard;
    logic [BLK_FIELD_W-1:0] next_blk [NUM_BLOCKS_DEF];
    logic [BLK_FIELD_W-1:0] free_head;
    logic [KEY_W-1:0]       dir_key   [MAX_OBJECTS_DEF];
    logic [BLK_FIELD_W-1:0] dir_first [MAX_OBJECTS_DEF];
    logic [BLK_FIELD_W-1:0] dir_last  [MAX_OBJECTS_DEF];
    int obj_count;
    pool_reply_t pending_replies[$];
    int n_noted;
    int n_checked;
    int n_fail;
    int status_seen[8];

    function new();
      for (int i = 0; i < NUM_BLOCKS_DEF; i++)
        next_blk[i] = (i == NUM_BLOCKS_DEF - 1) ? '0 : BLK_FIELD_W'(i + 1);
      free_head = 1;
      obj_count = 0;
      n_noted = 0;
      n_checked = 0;
      n_fail = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function logic [BLK_FIELD_W-1:0] take_block();
      logic [BLK_FIELD_W-1:0] b;
      b = free_head;
      if (b != 0) begin
        free_head = next_blk[b];
        next_blk[b] = '0;
      end
      return b;
    endfunction

    // lowest matching index wins; duplicates are legal
    function int find_key(logic [KEY_W-1:0] key);
      for (int i = 0; i < obj_count; i++)
        if (dir_key[i] == key) return i;
      return -1;
    endfunction

    function pool_reply_t predict_pool_reply(logic [FUNC_W-1:0] fn, logic [KEY_W-1:0] key,
                                             logic [BLK_FIELD_W-1:0] b);
      pool_reply_t r;
      int e;
      r.block = '0;
      r.status = ST_OK;
      case (fn)
        FN_ALLOC: begin
          r.block = take_block();
          if (r.block == 0) r.status = ST_POOL_EMPTY;
        end
        FN_FREE: begin
          if (b == 0) r.status = ST_BAD_BLOCK;
          else begin
            next_blk[b] = free_head;
            free_head = b;
          end
        end
        FN_CREATE: begin
          if (obj_count >= MAX_OBJECTS_DEF) r.status = ST_DIR_FULL;
          else begin
            r.block = take_block();
            if (r.block == 0) r.status = ST_POOL_EMPTY;
            else begin
              dir_key[obj_count] = key;
              dir_first[obj_count] = r.block;
              dir_last[obj_count] = r.block;
              obj_count++;
            end
          end
        end
        FN_APPEND: begin
          // block is checked before the name lookup
          if (b == 0) r.status = ST_BAD_BLOCK;
          else begin
            e = find_key(key);
            if (e < 0) r.status = ST_NOT_FOUND;
            else begin
              next_blk[dir_last[e]] = b;
              next_blk[b] = '0;
              dir_last[e] = b;
            end
          end
        end
        FN_DROP: begin
          e = find_key(key);
          if (e < 0) r.status = ST_NOT_FOUND;
          else begin
            next_blk[dir_last[e]] = free_head;
            free_head = dir_first[e];
            for (int i = e; i + 1 < obj_count; i++) begin
              dir_key[i] = dir_key[i + 1];
              dir_first[i] = dir_first[i + 1];
              dir_last[i] = dir_last[i + 1];
            end
            obj_count--;
          end
        end
        FN_GET_FIRST, FN_GET_LAST: begin
          e = find_key(key);
          if (e < 0) r.status = ST_NOT_FOUND;
          else r.block = (fn == FN_GET_FIRST) ? dir_first[e] : dir_last[e];
        end
        default: ;
      endcase
      return r;
    endfunction

    function pool_reply_t note_request(logic [FUNC_W-1:0] fn, logic [KEY_W-1:0] key,
                                       logic [BLK_FIELD_W-1:0] b);
      pool_reply_t r;
      r = predict_pool_reply(fn, key, b);
      pending_replies.push_back(r);
      status_seen[r.status]++;
      n_noted++;
      return r;
    endfunction

    task report_mismatch(string what);
      n_fail++;
      if (n_fail <= PRINT_CAP) $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    task check_result(logic [OUT_TDATA_W-1:0] tdata);
      pool_reply_t want;
      logic [BLK_FIELD_W-1:0] got_blk;
      logic [STATUS_W-1:0] got_st;
      got_blk = tdata[BLK_FIELD_W-1:0];
      got_st = tdata[BLK_FIELD_W +: STATUS_W];
      n_checked++;
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("reply %0d with no request outstanding", n_checked));
      end else begin
        want = pending_replies.pop_front();
        if (got_blk !== want.block)
          report_mismatch($sformatf("reply %0d result_block got %0d expected %0d",
                                    n_checked, got_blk, want.block));
        if (got_st !== want.status)
          report_mismatch($sformatf("reply %0d status got %0d expected %0d",
                                    n_checked, got_st, want.status));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [IN_TUSER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  bit quiet_mode = 1'b0;
  pool_scoreboard sb = new();
  logic [BLK_FIELD_W-1:0] held_blocks[$];
  pool_reply_t last_reply;

  linked_block_pool_manager_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(64'd20_000_000);
    $display("Test completed with failures");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (quiet_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [KEY_W-1:0] fresh_key();
    int r;
    r = $urandom_range(0, 99);
    // a few recurring keys so duplicates and near misses show up
    if (r < 8) return KEY_ZERO;
    if (r < 14) return KEY_ONES;
    if (r < 22) return KEY_W'($urandom_range(1, 4));
    return {$urandom, $urandom};
  endfunction

  function automatic logic [KEY_W-1:0] live_key();
    if (sb.obj_count == 0) return fresh_key();
    return sb.dir_key[$urandom_range(0, sb.obj_count - 1)];
  endfunction

  function automatic logic [BLK_FIELD_W-1:0] pop_held();
    int idx;
    logic [BLK_FIELD_W-1:0] b;
    if (held_blocks.size() == 0) return '0;
    idx = $urandom_range(0, held_blocks.size() - 1);
    b = held_blocks[idx];
    held_blocks.delete(idx);
    return b;
  endfunction

  // One request transfer; valid is only dropped for a gap before it.
  task automatic send_request(input logic [FUNC_W-1:0] fn, input logic [KEY_W-1:0] key,
                              input logic [BLK_FIELD_W-1:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_TDATA_W - KEY_W - BLK_FIELD_W){1'b0}}, b, key};
    in_tuser <= {{(IN_TUSER_W - FUNC_W){1'b0}}, fn};
    do @(posedge clk); while (!in_tready);
    last_reply = sb.note_request(fn, key, b);
    if (fn == FN_ALLOC && last_reply.status == ST_OK) held_blocks.push_back(last_reply.block);
  endtask

  // result side: random back-pressure, all ready during quiet stretches
  initial begin : result_sink
    int hold;
    bit level;
    hold = 0;
    level = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
      if (hold == 0) begin
        level = ($urandom_range(0, 99) < 65);
        if (level) hold = $urandom_range(1, 20);
        else if ($urandom_range(0, 9) < 8) hold = $urandom_range(1, 3);
        else hold = $urandom_range(15, 60);
      end
      hold--;
      out_tready <= quiet_mode ? 1'b1 : level;
    end
  end

  initial begin : stimulus
    int pick;
    int guard;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: unused code, bad-block and not-found errors, duplicates, compaction
    send_request(FN_UNUSED, KEY_ONES, 10'h3ff);
    send_request(FN_ALLOC, {$urandom, $urandom}, 10'h2aa);
    send_request(FN_FREE, KEY_ZERO, '0);
    send_request(FN_FREE, KEY_ONES, pop_held());
    send_request(FN_GET_FIRST, KEY_ZERO, '0);
    send_request(FN_GET_LAST, KEY_ONES, '0);
    send_request(FN_DROP, KEY_ZERO, '0);
    send_request(FN_APPEND, KEY_ZERO, '0);
    send_request(FN_APPEND, KEY_ONES, 10'h3ff);
    send_request(FN_CREATE, KEY_ZERO, 10'h3ff);
    send_request(FN_APPEND, KEY_ZERO, '0);
    send_request(FN_CREATE, KEY_ONES, '0);
    send_request(FN_CREATE, KEY_ZERO, 10'h155);
    send_request(FN_ALLOC, KEY_ZERO, '0);
    send_request(FN_APPEND, KEY_ONES, pop_held());
    send_request(FN_ALLOC, KEY_ONES, '0);
    send_request(FN_APPEND, KEY_ZERO, pop_held());
    send_request(FN_GET_FIRST, KEY_ONES, '0);
    send_request(FN_GET_LAST, KEY_ONES, '0);
    send_request(FN_GET_LAST, KEY_ZERO, '0);
    send_request(FN_DROP, KEY_ZERO, '0);
    send_request(FN_GET_FIRST, KEY_ZERO, '0);
    send_request(FN_DROP, KEY_ONES, '0);
    send_request(FN_ALLOC, KEY_ZERO, '0);

    // fill the directory past capacity, then thin it out
    guard = 0;
    do begin
      send_request(FN_CREATE, fresh_key(), BLK_FIELD_W'($urandom));
      guard++;
    end while (last_reply.status != ST_DIR_FULL && guard < 2 * MAX_OBJECTS_DEF);
    send_request(FN_GET_LAST, sb.dir_key[MAX_OBJECTS_DEF - 1], '0);
    send_request(FN_DROP, sb.dir_key[MAX_OBJECTS_DEF - 1], '0);
    while (sb.obj_count > MAX_OBJECTS_DEF / 2)
      send_request(FN_DROP, live_key(), BLK_FIELD_W'($urandom));

    // random: mostly well-formed object traffic, some misses and raw noise
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 200) quiet_mode <= 1'b1;
      if (n == 260) quiet_mode <= 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 14) begin
        send_request(FN_CREATE, fresh_key(), BLK_FIELD_W'($urandom));
      end else if (pick < 28) begin
        send_request(FN_ALLOC, {$urandom, $urandom}, BLK_FIELD_W'($urandom));
      end else if (pick < 44) begin
        if (held_blocks.size() > 0 && sb.obj_count > 0)
          send_request(FN_APPEND, live_key(), pop_held());
        else
          send_request(FN_ALLOC, {$urandom, $urandom}, BLK_FIELD_W'($urandom));
      end else if (pick < 54) begin
        send_request(FN_FREE, {$urandom, $urandom}, pop_held());
      end else if (pick < 63) begin
        send_request(FN_DROP, live_key(), BLK_FIELD_W'($urandom));
      end else if (pick < 80) begin
        send_request($urandom_range(0, 1) ? FN_GET_FIRST : FN_GET_LAST, live_key(),
                     BLK_FIELD_W'($urandom));
      end else if (pick < 88) begin
        send_request(FUNC_W'($urandom_range(FN_APPEND, FN_GET_LAST)), {$urandom, $urandom},
                     BLK_FIELD_W'($urandom_range(0, NUM_BLOCKS_DEF - 1)));
      end else begin
        // misuse: arbitrary blocks may corrupt chains, the model follows along
        send_request(FUNC_W'($urandom_range(0, 7)), fresh_key(),
                     BLK_FIELD_W'($urandom_range(0, NUM_BLOCKS_DEF - 1)));
      end
    end

    // cut the free list down to its head by appending that head to an object, then run
    // the pool dry on allocate and create without idling and hand held blocks back
    quiet_mode <= 1'b1;
    if (sb.obj_count == MAX_OBJECTS_DEF) send_request(FN_DROP, live_key(), '0);
    if (sb.obj_count == 0) send_request(FN_CREATE, fresh_key(), '0);
    if (sb.free_head != 0 && sb.obj_count > 0)
      send_request(FN_APPEND, live_key(), sb.free_head);
    guard = 0;
    do begin
      send_request(FN_ALLOC, {$urandom, $urandom}, BLK_FIELD_W'($urandom));
      guard++;
    end while (last_reply.status != ST_POOL_EMPTY && guard < NUM_BLOCKS_DEF + 8);
    send_request(FN_ALLOC, KEY_ONES, '0);
    send_request(FN_CREATE, fresh_key(), '0);
    while (held_blocks.size() > 0)
      send_request(FN_FREE, {$urandom, $urandom}, pop_held());
    quiet_mode <= 1'b0;

    in_tvalid <= 1'b0;
    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (4 * MAX_OBJECTS_DEF + 16) @(posedge clk);

    $display("Covered %0d requests, %0d replies checked, %0d mismatches", sb.n_noted,
             sb.n_checked, sb.n_fail);
    $display("Status mix ok/not-found/pool-empty/dir-full/bad-block: %0d/%0d/%0d/%0d/%0d",
             sb.status_seen[ST_OK], sb.status_seen[ST_NOT_FOUND],
             sb.status_seen[ST_POOL_EMPTY], sb.status_seen[ST_DIR_FULL],
             sb.status_seen[ST_BAD_BLOCK]);
    if (sb.n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/lbpm_pkg.sv
hdl/lbpm_ram.sv
hdl/linked_block_pool_manager_core.sv
hdl/lbpm_checker.sv
dv/tb.sv
